// ===== design/jjpi_pkg.sv =====
// ----------------------------------------------------------------------------
// jjpi_pkg
// Shared types, codes, joint limits and the clamp function of the jog
// position integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package jjpi_pkg;

  localparam int unsigned NumJoints = 4;
  localparam int unsigned JointW    = 2;
  localparam int unsigned TargetW   = 19;
  localparam int unsigned SumW      = 33;

  typedef enum logic [1:0] {
    CmdJoy   = 2'd0,
    CmdState = 2'd1,
    CmdTick  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    CfgDeadzone  = 3'd0,
    CfgRescale   = 3'd1,
    CfgGain      = 3'd2,
    CfgEnableIdx = 3'd3,
    CfgStopIdx   = 3'd4
  } cfg_idx_e;

  // joint limits, radians signed Q2.16
  localparam logic signed [TargetW-1:0] LowerLim [NumJoints] =
    '{-19'sd205783, -19'sd36045, -19'sd205783, -19'sd20316};
  localparam logic signed [TargetW-1:0] UpperLim [NumJoints] =
    '{19'sd205783, 19'sd203162, 19'sd205783, 19'sd183501};

  // step sequencing for the shared axis unit
  typedef struct packed {
    logic              mag_en;
    logic              scale_en;
    logic              gain_en;
    logic [JointW-1:0] joint;
  } axis_ctrl_t;

  function automatic logic signed [TargetW-1:0] clamp_joint(
    input logic signed [SumW-1:0] v,
    input logic [JointW-1:0]      j
  );
    logic signed [SumW-1:0]    lo;
    logic signed [SumW-1:0]    hi;
    logic signed [TargetW-1:0] r;
    lo = SumW'(LowerLim[j]);
    hi = SumW'(UpperLim[j]);
    if (v < lo) begin
      r = LowerLim[j];
    end else if (v > hi) begin
      r = UpperLim[j];
    end else begin
      r = v[TargetW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/jjpi_if.sv =====
// ----------------------------------------------------------------------------
// jjpi_if
// Valid/ready channels of the jog position integrator: input items, result
// items and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface jjpi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [15:0] axis_0;
  logic signed [15:0] axis_1;
  logic signed [15:0] axis_2;
  logic signed [15:0] axis_3;
  logic               axes_complete;
  logic [15:0]        buttons;
  logic signed [31:0] pos_0;
  logic signed [31:0] pos_1;
  logic signed [31:0] pos_2;
  logic signed [31:0] pos_3;
  logic [3:0]         pos_present;

  modport source (
    output valid, cmd, axis_0, axis_1, axis_2, axis_3, axes_complete, buttons,
           pos_0, pos_1, pos_2, pos_3, pos_present,
    input  ready
  );
  modport sink (
    input  valid, cmd, axis_0, axis_1, axis_2, axis_3, axes_complete, buttons,
           pos_0, pos_1, pos_2, pos_3, pos_present,
    output ready
  );
endinterface

interface jjpi_out_if;
  logic               valid;
  logic               ready;
  logic signed [18:0] target_0;
  logic signed [18:0] target_1;
  logic signed [18:0] target_2;
  logic signed [18:0] target_3;

  modport source (
    output valid, target_0, target_1, target_2, target_3,
    input  ready
  );
  modport sink (
    input  valid, target_0, target_1, target_2, target_3,
    output ready
  );
endinterface

interface jjpi_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/jjpi_axis_unit.sv =====
// ----------------------------------------------------------------------------
// jjpi_axis_unit
// One joint step at a time: magnitude and deadzone, rescale and gain on a
// single shared 16x16 multiplier, then accumulate and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module jjpi_axis_unit (
  input  wire logic                                   clk_i,
  input  wire jjpi_pkg::axis_ctrl_t                   ctrl_i,
  input  wire logic signed [15:0]                     axis_i,
  input  wire logic signed [jjpi_pkg::TargetW-1:0]    target_i,
  input  wire logic [14:0]                            deadzone_i,
  input  wire logic [15:0]                            rescale_i,
  input  wire logic [15:0]                            gain_i,
  output logic signed [jjpi_pkg::TargetW-1:0]         target_o
);

  logic [15:0] diff_q, diff_d;
  logic        zero_q, zero_d;
  logic        neg_q, neg_d;
  logic [15:0] s_q, s_d;
  logic [16:0] mag_q, mag_d;

  logic [16:0] m;
  logic [15:0] op_a, op_b;
  logic [31:0] prod;
  logic [32:0] rnd;
  logic [20:0] s_wide;
  logic        step_neg;
  logic signed [17:0]                  delta;
  logic signed [jjpi_pkg::SumW-1:0]    sum;

  // magnitude of the axis, 0..32768
  always_comb begin
    m      = axis_i[15] ? (17'd0 - {axis_i[15], axis_i}) : {1'b0, axis_i};
    zero_d = m < {2'b00, deadzone_i};
    diff_d = 16'(m - {2'b00, deadzone_i});
    neg_d  = axis_i[15];
  end

  // shared multiplier: deadzone rescale, then step gain
  always_comb begin
    op_a   = ctrl_i.scale_en ? diff_q : s_q;
    op_b   = ctrl_i.scale_en ? rescale_i : gain_i;
    prod   = op_a * op_b;
    rnd    = ctrl_i.scale_en ? ({1'b0, prod} + 33'd2048) : ({1'b0, prod} + 33'd16384);
    s_wide = rnd[32:12];
    if (zero_q) begin
      s_d = 16'd0;
    end else if (s_wide > 21'd32768) begin
      s_d = 16'd32768;
    end else begin
      s_d = s_wide[15:0];
    end
    mag_d = rnd[31:15];
  end

  // joints 1 and 3 run inverted
  always_comb begin
    step_neg = neg_q ^ ctrl_i.joint[0];
    delta    = step_neg ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
    sum      = jjpi_pkg::SumW'(target_i) + jjpi_pkg::SumW'(delta);
    target_o = jjpi_pkg::clamp_joint(sum, ctrl_i.joint);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mag_en) begin
      diff_q <= diff_d;
      zero_q <= zero_d;
      neg_q  <= neg_d;
    end
    if (ctrl_i.scale_en) begin
      s_q <= s_d;
    end
    if (ctrl_i.gain_en) begin
      mag_q <= mag_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/joystick_jog_position_integrator.sv =====
// ----------------------------------------------------------------------------
// joystick_jog_position_integrator
// Joystick jog of four joint targets with deadman enable, latching stop,
// one-time seeding from joint state and gated publishing.
// ----------------------------------------------------------------------------
// A joystick word with enable held and all axes present steps each joint
// through the shared axis unit (magnitude, deadzone rescale, gain, accumulate
// and clamp), one multiplier doing both products; no word is taken before
// the last joint ends. Every other word (stop, release, joint state, tick,
// unknown code) is handled on acceptance. A qualifying tick shows its targets
// on the output register the cycle after it is accepted; the next word is
// taken while a result waits only if the sink takes that result in the same
// cycle. Configuration writes are taken at any time, one per cycle.
`default_nettype none

module joystick_jog_position_integrator (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  jjpi_in_if.sink     in_i,
  jjpi_out_if.source  out_o,
  jjpi_cfg_if.sink    cfg_i
);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StMag   = 5'b00010,
    StScale = 5'b00100,
    StGain  = 5'b01000,
    StAcc   = 5'b10000
  } state_e;

  localparam int unsigned NJ = jjpi_pkg::NumJoints;
  localparam int unsigned TW = jjpi_pkg::TargetW;

  state_e state_q, state_d;
  logic [jjpi_pkg::JointW-1:0] joint_q, joint_d;

  logic [14:0] deadzone_q;
  logic [15:0] rescale_q;
  logic [15:0] gain_q;
  logic [3:0]  enable_idx_q;
  logic [3:0]  stop_idx_q;

  logic seeded_q, enabled_q, stopped_q;
  logic signed [TW-1:0] target_q [NJ];
  logic signed [15:0]   axis_q [NJ];

  logic                 out_valid_q;
  logic signed [TW-1:0] out_target_q [NJ];

  logic signed [15:0] axis_in [NJ];
  logic signed [31:0] pos_in [NJ];
  logic               in_fire, out_fire;
  logic               stop_btn, enable_btn;
  logic               is_joy, is_state, is_tick;
  logic               start_seq, publish;
  jjpi_pkg::axis_ctrl_t ctrl;
  logic signed [TW-1:0] step_target;

  assign in_fire  = in_i.valid & in_i.ready;
  assign out_fire = out_o.valid & out_o.ready;

  assign in_i.ready  = (state_q == StIdle) && (!out_valid_q || out_o.ready);
  assign cfg_i.ready = 1'b1;

  always_comb begin
    axis_in[0] = in_i.axis_0;
    axis_in[1] = in_i.axis_1;
    axis_in[2] = in_i.axis_2;
    axis_in[3] = in_i.axis_3;
    pos_in[0]  = in_i.pos_0;
    pos_in[1]  = in_i.pos_1;
    pos_in[2]  = in_i.pos_2;
    pos_in[3]  = in_i.pos_3;
  end

  // command decode
  always_comb begin
    is_joy   = 1'b0;
    is_state = 1'b0;
    is_tick  = 1'b0;
    unique case (jjpi_pkg::cmd_e'(in_i.cmd))
      jjpi_pkg::CmdJoy:   is_joy   = 1'b1;
      jjpi_pkg::CmdState: is_state = 1'b1;
      jjpi_pkg::CmdTick:  is_tick  = 1'b1;
      default: ;
    endcase
  end

  assign stop_btn   = in_i.buttons[stop_idx_q];
  assign enable_btn = in_i.buttons[enable_idx_q];
  assign start_seq  = in_fire && is_joy && !stop_btn && enable_btn && in_i.axes_complete;
  assign publish    = in_fire && is_tick && seeded_q && enabled_q && !stopped_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    joint_d = joint_q;
    unique case (state_q)
      StIdle: begin
        if (start_seq) begin
          state_d = StMag;
          joint_d = '0;
        end
      end
      StMag:   state_d = StScale;
      StScale: state_d = StGain;
      StGain:  state_d = StAcc;
      StAcc: begin
        if (joint_q == jjpi_pkg::JointW'(NJ - 1)) begin
          state_d = StIdle;
        end else begin
          state_d = StMag;
          joint_d = joint_q + 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    ctrl.mag_en   = (state_q == StMag);
    ctrl.scale_en = (state_q == StScale);
    ctrl.gain_en  = (state_q == StGain);
    ctrl.joint    = joint_q;
  end

  jjpi_axis_unit u_axis (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .axis_i     (axis_q[joint_q]),
    .target_i   (target_q[joint_q]),
    .deadzone_i (deadzone_q),
    .rescale_i  (rescale_q),
    .gain_i     (gain_q),
    .target_o   (step_target)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      joint_q <= '0;
    end else begin
      state_q <= state_d;
      joint_q <= joint_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q   <= 15'd3277;
      rescale_q    <= 16'd4551;
      gain_q       <= 16'd1966;
      enable_idx_q <= 4'd4;
      stop_idx_q   <= 4'd5;
    end else if (cfg_i.valid) begin
      unique case (jjpi_pkg::cfg_idx_e'(cfg_i.index))
        jjpi_pkg::CfgDeadzone:  deadzone_q   <= cfg_i.data[14:0];
        jjpi_pkg::CfgRescale:   rescale_q    <= cfg_i.data;
        jjpi_pkg::CfgGain:      gain_q       <= cfg_i.data;
        jjpi_pkg::CfgEnableIdx: enable_idx_q <= cfg_i.data[3:0];
        jjpi_pkg::CfgStopIdx:   stop_idx_q   <= cfg_i.data[3:0];
        default: ;
      endcase
    end
  end

  // flags; stop wins over enable
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q  <= 1'b0;
      enabled_q <= 1'b0;
      stopped_q <= 1'b0;
    end else if (in_fire) begin
      if (is_joy) begin
        if (stop_btn) begin
          stopped_q <= 1'b1;
        end else if (enable_btn) begin
          enabled_q <= 1'b1;
          stopped_q <= 1'b0;
        end else begin
          enabled_q <= 1'b0;
        end
      end
      if (is_state) begin
        seeded_q <= 1'b1;
      end
    end
  end

  // joint targets: seeded once, then stepped by the axis unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NJ; j++) begin
        target_q[j] <= '0;
      end
    end else begin
      for (int j = 0; j < NJ; j++) begin
        if (in_fire && is_state && !seeded_q && in_i.pos_present[j]) begin
          target_q[j] <= jjpi_pkg::clamp_joint(jjpi_pkg::SumW'(pos_in[j]),
                                               jjpi_pkg::JointW'(j));
        end else if (state_q == StAcc && joint_q == jjpi_pkg::JointW'(j)) begin
          target_q[j] <= step_target;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_seq) begin
      for (int j = 0; j < NJ; j++) begin
        axis_q[j] <= axis_in[j];
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (publish) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (publish) begin
      for (int j = 0; j < NJ; j++) begin
        out_target_q[j] <= target_q[j];
      end
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.target_0 = out_target_q[0];
  assign out_o.target_1 = out_target_q[1];
  assign out_o.target_2 = out_target_q[2];
  assign out_o.target_3 = out_target_q[3];

  // assertions
  a_publish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    publish |=> out_valid_q)
    else $error("qualifying tick did not load the output word");

  a_seq_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StAcc && joint_q == jjpi_pkg::JointW'(NJ - 1)) |=> state_q == StIdle)
    else $error("sequencer did not return to idle after the last joint");

  a_no_publish_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_tick && stopped_q) |=> !$rose(out_valid_q))
    else $error("word published while stopped");

  a_joint1_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (target_q[1] >= jjpi_pkg::LowerLim[1]) && (target_q[1] <= jjpi_pkg::UpperLim[1]))
    else $error("joint 1 target outside its limits");

endmodule

`default_nettype wire

// ===== tb/sv/tb_joystick_jog_position_integrator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_joystick_jog_position_integrator
// Self-checking bench for the jog position integrator. Joystick, joint state,
// tick and unknown words go in through a bursty driver. A predictor tracks
// the joint targets, seeding and the enable/stop flags. Each published word
// is checked field by field against the oldest predicted target set. The run
// steps through several register settings, extremes included.
// ----------------------------------------------------------------------------

module tb_joystick_jog_position_integrator;

  localparam int          CycleLimit   = 200000;
  localparam int          SettleCycles = 40;
  localparam int          MaxPrinted   = 40;
  localparam logic [1:0]  CmdUnknown   = 2'd3;
  localparam logic [2:0]  CfgUnused    = 3'd7;
  // button masks for the enable and stop bits at their reset positions
  localparam logic [15:0] EnableBtn    = 16'h0010;
  localparam logic [15:0] StopBtn      = 16'h0020;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [3:0][15:0] axis;
    logic             complete;
    logic [15:0]      buttons;
    logic [3:0][31:0] pos;
    logic [3:0]       present;
  } jog_word_t;

  typedef logic [3:0][18:0] target_set_t;

  logic clk_i;
  logic rst_ni;

  jjpi_in_if  in_if ();
  jjpi_out_if out_if ();
  jjpi_cfg_if cfg_if ();

  joystick_jog_position_integrator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // predictor state and register copies
  longint jt_target [4];
  bit     jt_seeded;
  bit     jt_enabled;
  bit     jt_stopped;
  longint dz_width;
  longint dz_rescale;
  longint gain_per_tick;
  int     enable_bit;
  int     stop_bit;

  jog_word_t   pending_words [$];
  target_set_t expected_targets [$];
  jog_word_t   cur_word;
  bit          in_taken = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          rdy_mode = 0;
  int          rdy_left = 0;
  int          err_count = 0;
  int          cycle_count = 0;

  always #4 clk_i = ~clk_i;

  initial begin
    clk_i                = 1'b0;
    rst_ni               = 1'b0;
    in_if.valid          = 1'b0;
    in_if.cmd            = '0;
    in_if.axis_0         = '0;
    in_if.axis_1         = '0;
    in_if.axis_2         = '0;
    in_if.axis_3         = '0;
    in_if.axes_complete  = 1'b0;
    in_if.buttons        = '0;
    in_if.pos_0          = '0;
    in_if.pos_1          = '0;
    in_if.pos_2          = '0;
    in_if.pos_3          = '0;
    in_if.pos_present    = '0;
    out_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = '0;
    cfg_if.data          = '0;
    dz_width             = 3277;
    dz_rescale           = 4551;
    gain_per_tick        = 1966;
    enable_bit           = 4;
    stop_bit             = 5;
    for (int j = 0; j < 4; j++) begin
      jt_target[j] = 0;
    end
    jt_seeded  = 1'b0;
    jt_enabled = 1'b0;
    jt_stopped = 1'b0;
  end

  task automatic report_error(string msg);
    if (err_count < MaxPrinted) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
    err_count++;
  endtask

  function automatic void queue_word(jog_word_t w);
    pending_words = {pending_words, w};
  endfunction

  function automatic longint limit_joint(longint v, int j);
    longint lo;
    longint hi;
    lo = longint'(jjpi_pkg::LowerLim[j]);
    hi = longint'(jjpi_pkg::UpperLim[j]);
    if (v < lo) begin
      return lo;
    end else if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // signed Q16.16 step for one Q1.15 axis
  function automatic longint axis_delta(logic [15:0] raw);
    longint a;
    longint m;
    longint s;
    longint d;
    a = longint'($signed(raw));
    m = (a < 0) ? -a : a;
    if (m < dz_width) begin
      return 0;
    end
    s = ((m - dz_width) * dz_rescale + 2048) >> 12;
    if (s > 32768) begin
      s = 32768;
    end
    d = (s * gain_per_tick + 16384) >> 15;
    return (a > 0) ? d : -d;
  endfunction

  function automatic void apply_word(jog_word_t w);
    longint      d;
    target_set_t t;
    case (w.cmd)
      jjpi_pkg::CmdJoy: begin
        if (w.buttons[stop_bit]) begin
          jt_stopped = 1'b1;
        end else if (w.buttons[enable_bit]) begin
          jt_enabled = 1'b1;
          jt_stopped = 1'b0;
          if (w.complete) begin
            for (int j = 0; j < 4; j++) begin
              d = axis_delta(w.axis[j]);
              if (j == 1 || j == 3) begin
                d = -d;
              end
              jt_target[j] = limit_joint(jt_target[j] + d, j);
            end
          end
        end else begin
          jt_enabled = 1'b0;
        end
      end
      jjpi_pkg::CmdState: begin
        if (!jt_seeded) begin
          for (int j = 0; j < 4; j++) begin
            if (w.present[j]) begin
              jt_target[j] = limit_joint(longint'($signed(w.pos[j])), j);
            end
          end
        end
        jt_seeded = 1'b1;
      end
      jjpi_pkg::CmdTick: begin
        if (jt_seeded && jt_enabled && !jt_stopped) begin
          for (int j = 0; j < 4; j++) begin
            t[j] = jt_target[j][18:0];
          end
          expected_targets = {expected_targets, t};
        end
      end
      default: begin
      end
    endcase
  endfunction

  // word builders
  function automatic jog_word_t noise_word(logic [1:0] cmd);
    jog_word_t w;
    w.cmd      = cmd;
    w.axis     = {$urandom(), $urandom()};
    w.complete = 1'($urandom_range(1));
    w.buttons  = 16'($urandom());
    w.pos      = {$urandom(), $urandom(), $urandom(), $urandom()};
    w.present  = 4'($urandom());
    return w;
  endfunction

  function automatic jog_word_t joy_word(logic [15:0] btn, logic full, logic [15:0] a0,
                                         logic [15:0] a1, logic [15:0] a2, logic [15:0] a3);
    jog_word_t w;
    w          = noise_word(jjpi_pkg::CmdJoy);
    w.buttons  = btn;
    w.complete = full;
    w.axis     = {a3, a2, a1, a0};
    return w;
  endfunction

  function automatic jog_word_t state_word(logic [3:0] present, logic [31:0] p0,
                                           logic [31:0] p1, logic [31:0] p2, logic [31:0] p3);
    jog_word_t w;
    w         = noise_word(jjpi_pkg::CmdState);
    w.present = present;
    w.pos     = {p3, p2, p1, p0};
    return w;
  endfunction

  function automatic logic [15:0] pick_axis();
    int v;
    case ($urandom_range(4))
      0, 1: return 16'($urandom());
      2: begin
        case ($urandom_range(3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h8001;
          default: return 16'h0001;
        endcase
      end
      3: begin
        // straddle the deadzone edge
        v = int'(dz_width) + int'($urandom_range(4)) - 2;
        if (v < 0) begin
          v = 0;
        end
        if (v > 32767) begin
          v = 32767;
        end
        return $urandom_range(1) ? 16'(-v) : 16'(v);
      end
      default: return 16'h0000;
    endcase
  endfunction

  function automatic jog_word_t random_word();
    jog_word_t w;
    int        r;
    r = $urandom_range(99);
    if (r < 55) begin
      w = noise_word(jjpi_pkg::CmdJoy);
      for (int j = 0; j < 4; j++) begin
        w.axis[j] = pick_axis();
      end
      w.buttons[stop_bit] = 1'b0;
      if ($urandom_range(99) < 85) begin
        w.buttons[enable_bit] = 1'b1;
      end
      if ($urandom_range(99) < 8) begin
        w.buttons[stop_bit] = 1'b1;
      end
      w.complete = ($urandom_range(9) != 0);
    end else if (r < 85) begin
      w = noise_word(jjpi_pkg::CmdTick);
    end else if (r < 92) begin
      w = noise_word(jjpi_pkg::CmdState);
    end else if (r < 95) begin
      w = noise_word(CmdUnknown);
    end else begin
      w = noise_word(jjpi_pkg::CmdJoy);
    end
    return w;
  endfunction

  task automatic push_random(int n);
    repeat (n) begin
      queue_word(random_word());
    end
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk_i);
    end while (pending_words.size() != 0 || in_if.valid || expected_targets.size() != 0);
  endtask

  // a joystick word gives no result, so leave room for its axis passes
  task automatic settle();
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      jjpi_pkg::CfgDeadzone:  dz_width      = val[14:0];
      jjpi_pkg::CfgRescale:   dz_rescale    = val;
      jjpi_pkg::CfgGain:      gain_per_tick = val;
      jjpi_pkg::CfgEnableIdx: enable_bit    = val[3:0];
      jjpi_pkg::CfgStopIdx:   stop_bit      = val[3:0];
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_config(logic [15:0] dz, logic [15:0] resc, logic [15:0] gain,
                            logic [15:0] en_idx, logic [15:0] st_idx);
    write_reg(jjpi_pkg::CfgDeadzone, dz);
    write_reg(jjpi_pkg::CfgRescale, resc);
    write_reg(jjpi_pkg::CfgGain, gain);
    write_reg(jjpi_pkg::CfgEnableIdx, en_idx);
    write_reg(jjpi_pkg::CfgStopIdx, st_idx);
  endtask

  // input driver: bursts with random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        cur_word = pending_words.pop_front();
        in_if.cmd           <= cur_word.cmd;
        in_if.axis_0        <= cur_word.axis[0];
        in_if.axis_1        <= cur_word.axis[1];
        in_if.axis_2        <= cur_word.axis[2];
        in_if.axis_3        <= cur_word.axis[3];
        in_if.axes_complete <= cur_word.complete;
        in_if.buttons       <= cur_word.buttons;
        in_if.pos_0         <= cur_word.pos[0];
        in_if.pos_1         <= cur_word.pos[1];
        in_if.pos_2         <= cur_word.pos[2];
        in_if.pos_3         <= cur_word.pos[3];
        in_if.pos_present   <= cur_word.present;
        in_if.valid         <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(16, 1);
          gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
        end else begin
          burst_left--;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result sink: stall pattern switches between modes
  always @(negedge clk_i) begin
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(3);
      rdy_left = $urandom_range(100, 10);
    end else begin
      rdy_left--;
    end
    case (rdy_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= 1'($urandom_range(1));
      2: out_if.ready <= ($urandom_range(4) == 0);
      default: out_if.ready <= ~out_if.ready;
    endcase
  end

  // monitor and checker
  always @(posedge clk_i) begin
    target_set_t got;
    target_set_t want;
    in_taken <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = {out_if.target_3, out_if.target_2, out_if.target_1, out_if.target_0};
        if (expected_targets.size() == 0) begin
          report_error("result word with no qualifying tick pending");
        end else begin
          want = expected_targets.pop_front();
          for (int j = 0; j < 4; j++) begin
            if (got[j] !== want[j]) begin
              report_error($sformatf("target_%0d got %0d expected %0d", j,
                                     $signed(got[j]), $signed(want[j])));
            end
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        apply_word(cur_word);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("joystick_jog_position_integrator test failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part, reset register values
    queue_word(noise_word(jjpi_pkg::CmdTick));
    queue_word(joy_word(EnableBtn | StopBtn, 1'b1, 16'h7FFF, 16'h8000,
                        16'h7FFF, 16'h8000));
    // only joints 1 and 3 present, both far outside their limits
    queue_word(state_word(4'b1010, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h8000_0000));
    queue_word(state_word(4'b1111, 32'h0001_0000, 32'h0002_0000,
                          32'hFFFF_0000, 32'h0000_0001));
    queue_word(state_word(4'b0000, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h0000_0000, 32'hFFFF_FFFF));
    queue_word(noise_word(jjpi_pkg::CmdTick));
    queue_word(joy_word(EnableBtn, 1'b0, 16'h7FFF, 16'h8000,
                        16'h7FFF, 16'h8000));
    queue_word(noise_word(jjpi_pkg::CmdTick));
    queue_word(joy_word(EnableBtn, 1'b1, 16'h7FFF, 16'h8000,
                        16'h8000, 16'h7FFF));
    queue_word(joy_word(EnableBtn, 1'b1, 16'd3276, -16'sd3276,
                        16'h0000, 16'hFFFF));
    queue_word(joy_word(EnableBtn, 1'b1, 16'd3277, -16'sd3277,
                        16'd3278, -16'sd3278));
    queue_word(noise_word(jjpi_pkg::CmdTick));
    queue_word(noise_word(CmdUnknown));
    queue_word(joy_word(StopBtn, 1'b1, 16'h7FFF, 16'h7FFF,
                        16'h7FFF, 16'h7FFF));
    queue_word(noise_word(jjpi_pkg::CmdTick));
    queue_word(joy_word(16'h0000, 1'b1, 16'h7FFF, 16'h7FFF,
                        16'h7FFF, 16'h7FFF));
    queue_word(noise_word(jjpi_pkg::CmdTick));
    queue_word(joy_word(~StopBtn, 1'b1, 16'h4000, 16'hC000,
                        16'h2000, 16'hE000));
    queue_word(noise_word(jjpi_pkg::CmdTick));
    queue_word(joy_word(16'hFFFF, 1'b1, 16'h7FFF, 16'h7FFF,
                        16'h7FFF, 16'h7FFF));
    queue_word(noise_word(jjpi_pkg::CmdTick));
    queue_word(joy_word(EnableBtn, 1'b1, 16'h8000, 16'h7FFF,
                        16'h8000, 16'h7FFF));
    queue_word(noise_word(jjpi_pkg::CmdTick));
    push_random(30);
    wait_drained();
    push_random(40);
    settle();

    // zero deadzone, largest rescale and gain: limits reached fast
    set_config(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd15);
    push_random(40);
    wait_drained();
    push_random(40);
    settle();

    // widest deadzone, zero rescale and gain, unused bits set in the data
    set_config(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFF0);
    write_reg(CfgUnused, 16'hFFFF);
    push_random(30);
    wait_drained();
    push_random(30);
    settle();

    // enable and stop on the same button: stop always wins
    set_config(16'd32767, 16'hFFFF, 16'hFFFF, 16'd7, 16'd7);
    push_random(25);
    wait_drained();
    push_random(25);
    settle();

    repeat (2) begin
      set_config(16'($urandom_range(8000)), 16'($urandom_range(65535)),
                 16'($urandom_range(65535)), 16'($urandom_range(15)),
                 16'($urandom_range(15)));
      push_random(45);
      wait_drained();
      push_random(45);
      settle();
    end

    if (err_count == 0) begin
      $display("joystick_jog_position_integrator test passed");
    end else begin
      $display("joystick_jog_position_integrator test failed");
    end
    $finish;
  end

endmodule
